FILE: hdl/gcic_pkg.sv
`timescale 1ns / 1ps
package gcic_pkg;

	localparam int MAX_AXIS = 1024;
	localparam int AXIS_W = $clog2(MAX_AXIS) + 1;
	localparam int COORD_W = $clog2(MAX_AXIS);
	localparam int PLANE_W = 2 * COORD_W + 1;
	localparam int TOTAL_W = 3 * COORD_W + 1;
	localparam int IDX_W = 3 * COORD_W;
	localparam int VAL_W = 32;
	localparam int OIDX_W = 31;
	localparam int REG_IDX_W = 2;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_SIZE_X = 2'd0,
		REG_SIZE_Y = 2'd1,
		REG_SIZE_Z = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [AXIS_W-1:0] sx;
		logic [AXIS_W-1:0] sy;
		logic [AXIS_W-1:0] sz;
	} size_t;

	localparam logic OP_TO_INDEX = 1'b0;
	localparam logic OP_TO_COORD = 1'b1;

endpackage

FILE: hdl/gcic_if.sv
`timescale 1ns / 1ps
interface gcic_in_if;
	logic valid;
	logic ready;
	logic op;
	logic wrap;
	logic signed [31:0] coord_x;
	logic signed [31:0] coord_y;
	logic signed [31:0] coord_z;
	logic signed [31:0] lin_index;

	modport source (output valid, op, wrap, coord_x, coord_y, coord_z, lin_index,
		input ready);
	modport sink (input valid, op, wrap, coord_x, coord_y, coord_z, lin_index,
		output ready);
endinterface

interface gcic_out_if;
	logic valid;
	logic ready;
	logic signed [30:0] out_index;
	logic signed [10:0] out_x;
	logic signed [10:0] out_y;
	logic signed [10:0] out_z;
	logic valid_res;

	modport source (output valid, out_index, out_x, out_y, out_z, valid_res,
		input ready);
	modport sink (input valid, out_index, out_x, out_y, out_z, valid_res,
		output ready);
endinterface

FILE: hdl/gcic_cfg.sv
`timescale 1ns / 1ps
module gcic_cfg (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  logic [gcic_pkg::REG_IDX_W-1:0] wr_idx,
	input  logic [gcic_pkg::AXIS_W-1:0] wr_data,
	output gcic_pkg::size_t size
);

	gcic_pkg::size_t size_q;
	logic [gcic_pkg::AXIS_W-1:0] eff;

	// zero acts as one, anything above the limit acts as the limit
	always_comb begin
		if (wr_data == '0) begin
			eff = gcic_pkg::AXIS_W'(1);
		end else if (wr_data > gcic_pkg::AXIS_W'(gcic_pkg::MAX_AXIS)) begin
			eff = gcic_pkg::AXIS_W'(gcic_pkg::MAX_AXIS);
		end else begin
			eff = wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q.sx <= gcic_pkg::AXIS_W'(1);
			size_q.sy <= gcic_pkg::AXIS_W'(1);
			size_q.sz <= gcic_pkg::AXIS_W'(1);
		end else if (wr_en) begin
			unique case (gcic_pkg::reg_idx_t'(wr_idx))
				gcic_pkg::REG_SIZE_X: size_q.sx <= eff;
				gcic_pkg::REG_SIZE_Y: size_q.sy <= eff;
				gcic_pkg::REG_SIZE_Z: size_q.sz <= eff;
				default: ;
			endcase
		end
	end

	assign size = size_q;

endmodule

FILE: hdl/gcic_div.sv
`timescale 1ns / 1ps
module gcic_div #(
	parameter int NW = 32,
	parameter int DW = 11,
	parameter int SW = 1
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_v,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [SW-1:0] side,
	output logic out_v,
	output logic [NW-1:0] quo,
	output logic [DW-1:0] rem,
	output logic [DW-1:0] den_out,
	output logic [SW-1:0] side_out
);

	// one quotient bit per stage, msb first; quo_s shifts the dividend out and
	// the quotient in
	logic v_s [NW];
	logic [NW-1:0] quo_s [NW];
	logic [DW-1:0] rem_s [NW];
	logic [DW-1:0] den_s [NW];
	logic [SW-1:0] side_s [NW];

	for (genvar k = 0; k < NW; k++) begin : g_stage
		logic p_v;
		logic [NW-1:0] p_quo;
		logic [DW-1:0] p_rem;
		logic [DW-1:0] p_den;
		logic [SW-1:0] p_side;
		logic [DW:0] trial;
		logic [DW:0] diff;
		logic ge;

		if (k == 0) begin : g_first
			assign p_v = in_v;
			assign p_quo = num;
			assign p_rem = '0;
			assign p_den = den;
			assign p_side = side;
		end else begin : g_next
			assign p_v = v_s[k-1];
			assign p_quo = quo_s[k-1];
			assign p_rem = rem_s[k-1];
			assign p_den = den_s[k-1];
			assign p_side = side_s[k-1];
		end

		assign trial = {p_rem, p_quo[NW-1]};
		assign ge = trial >= {1'b0, p_den};
		assign diff = trial - {1'b0, p_den};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= p_v;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				quo_s[k] <= {p_quo[NW-2:0], ge};
				rem_s[k] <= ge ? diff[DW-1:0] : trial[DW-1:0];
				den_s[k] <= p_den;
				side_s[k] <= p_side;
			end
		end
	end

	assign out_v = v_s[NW-1];
	assign quo = quo_s[NW-1];
	assign rem = rem_s[NW-1];
	assign den_out = den_s[NW-1];
	assign side_out = side_s[NW-1];

endmodule

FILE: hdl/grid_coord_index_convert.sv
`timescale 1ns / 1ps
// row-major 3d grid coordinate / linear index converter (x fastest, then y, z)
// din carries one conversion per transaction: op selects coordinates to index
// or index to coordinates, wrap selects floored-modulo wrapping over rejection.
// dout carries one result per transaction; rejected input returns the -1
// sentinel with valid_res low, and fields the op does not use read zero.
// axis sizes are written through wr_en / wr_idx / wr_data; the user must write
// them only while the block is idle, which the block itself does not enforce.
// zero acts as one and values above 1024 act as 1024. reset sets all three
// sizes to one and empties the pipeline. between din and dout lie three input
// stages, a 32-stage divider for the wrap modulo, a fixup stage, a 30-stage
// divider by size_x, a 20-stage divider by size_y and two multiply-add stages.
// throughput is one transaction per cycle while dout is not stalled. the whole
// pipeline advances together; when dout is stalled with a result waiting,
// din.ready drops and every stage holds its contents, nothing is lost or
// repeated.
module grid_coord_index_convert (
	input  logic clk,
	input  logic arst_n,
	gcic_in_if.sink din,
	gcic_out_if.source dout,
	input  logic wr_en,
	input  logic [gcic_pkg::REG_IDX_W-1:0] wr_idx,
	input  logic [gcic_pkg::AXIS_W-1:0] wr_data
);

	localparam int AW = gcic_pkg::AXIS_W;
	localparam int CW = gcic_pkg::COORD_W;
	localparam int TW = gcic_pkg::TOTAL_W;
	localparam int VW = gcic_pkg::VAL_W;
	localparam int XW = gcic_pkg::IDX_W;

	gcic_pkg::size_t size;
	logic en;

	gcic_cfg u_cfg (
		.clk(clk), .arst_n(arst_n), .wr_en(wr_en), .wr_idx(wr_idx),
		.wr_data(wr_data), .size(size)
	);

	// stage 1: capture and plane size
	logic v_s1, op_s1, wrap_s1;
	logic [VW-1:0] cx_s1, cy_s1, cz_s1, li_s1;
	logic [gcic_pkg::PLANE_W-1:0] plane_s1;
	// stage 2: total size
	logic v_s2, op_s2, wrap_s2;
	logic [VW-1:0] cx_s2, cy_s2, cz_s2, li_s2;
	logic [TW-1:0] total_s2;
	// stage 3: magnitudes, signs, rejection
	logic v_s3, op_s3, rej_s3;
	logic [VW-1:0] mag0_s3, mag1_s3, mag2_s3;
	logic neg0_s3, neg1_s3, neg2_s3;
	logic [TW-1:0] den0_s3;

	logic [2*AW-1:0] plane_full;
	logic [TW+AW-1:0] total_full;
	logic [VW-1:0] a0, a1, a2;
	logic rej_c;

	assign plane_full = size.sx * size.sy;
	assign total_full = plane_s1 * size.sz;

	function automatic logic [VW-1:0] magnitude(input logic [VW-1:0] v);
		return v[VW-1] ? (~v + VW'(1)) : v;
	endfunction

	function automatic logic out_of_axis(input logic [VW-1:0] v, input logic [AW-1:0] s);
		return v[VW-1] || (v[VW-2:0] >= (VW-1)'(s));
	endfunction

	always_comb begin
		if (op_s2 == gcic_pkg::OP_TO_INDEX) begin
			a0 = cx_s2;
			a1 = cy_s2;
			a2 = cz_s2;
			rej_c = !wrap_s2 && (out_of_axis(cx_s2, size.sx) || out_of_axis(cy_s2, size.sy)
				|| out_of_axis(cz_s2, size.sz));
		end else begin
			a0 = li_s2;
			a1 = '0;
			a2 = '0;
			rej_c = !wrap_s2 && (li_s2[VW-1] || (li_s2[VW-2:0] >= (VW-1)'(total_s2)));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= din.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1 <= din.op;
			wrap_s1 <= din.wrap;
			cx_s1 <= din.coord_x;
			cy_s1 <= din.coord_y;
			cz_s1 <= din.coord_z;
			li_s1 <= din.lin_index;
			plane_s1 <= plane_full[gcic_pkg::PLANE_W-1:0];
			op_s2 <= op_s1;
			wrap_s2 <= wrap_s1;
			cx_s2 <= cx_s1;
			cy_s2 <= cy_s1;
			cz_s2 <= cz_s1;
			li_s2 <= li_s1;
			total_s2 <= total_full[TW-1:0];
			op_s3 <= op_s2;
			rej_s3 <= rej_c;
			mag0_s3 <= magnitude(a0);
			mag1_s3 <= magnitude(a1);
			mag2_s3 <= magnitude(a2);
			neg0_s3 <= a0[VW-1];
			neg1_s3 <= a1[VW-1];
			neg2_s3 <= a2[VW-1];
			den0_s3 <= (op_s2 == gcic_pkg::OP_TO_INDEX) ? TW'(size.sx) : total_s2;
		end
	end

	// modulo of the magnitudes: lane 0 by size_x or total, lanes 1 and 2 by y, z
	logic v_d1;
	logic [2:0] side_d1;
	logic [TW-1:0] r0_d1, d0_d1;
	logic [AW-1:0] r1_d1, r2_d1, d1_d1, d2_d1;
	logic n1_d1, n2_d1;

	gcic_div #(.NW(VW), .DW(TW), .SW(3)) u_div_m0 (
		.clk(clk), .arst_n(arst_n), .en(en), .in_v(v_s3), .num(mag0_s3), .den(den0_s3),
		.side({op_s3, rej_s3, neg0_s3}), .out_v(v_d1), .quo(), .rem(r0_d1),
		.den_out(d0_d1), .side_out(side_d1)
	);
	gcic_div #(.NW(VW), .DW(AW), .SW(1)) u_div_m1 (
		.clk(clk), .arst_n(arst_n), .en(en), .in_v(v_s3), .num(mag1_s3), .den(size.sy),
		.side(neg1_s3), .out_v(), .quo(), .rem(r1_d1), .den_out(d1_d1),
		.side_out(n1_d1)
	);
	gcic_div #(.NW(VW), .DW(AW), .SW(1)) u_div_m2 (
		.clk(clk), .arst_n(arst_n), .en(en), .in_v(v_s3), .num(mag2_s3), .den(size.sz),
		.side(neg2_s3), .out_v(), .quo(), .rem(r2_d1), .den_out(d2_d1),
		.side_out(n2_d1)
	);

	// stage 4: floored modulo fixup for negative input
	logic v_s4, op_s4, rej_s4;
	logic [XW-1:0] idx_s4;
	logic [CW-1:0] x_s4, y_s4, z_s4;
	logic [TW-1:0] f0;
	logic [AW-1:0] f1, f2;

	assign f0 = (side_d1[0] && r0_d1 != '0) ? d0_d1 - r0_d1 : r0_d1;
	assign f1 = (n1_d1 && r1_d1 != '0) ? d1_d1 - r1_d1 : r1_d1;
	assign f2 = (n2_d1 && r2_d1 != '0) ? d2_d1 - r2_d1 : r2_d1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_d1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s4 <= side_d1[2];
			rej_s4 <= side_d1[1];
			idx_s4 <= f0[XW-1:0];
			x_s4 <= f0[CW-1:0];
			y_s4 <= f1[CW-1:0];
			z_s4 <= f2[CW-1:0];
		end
	end

	// index split: by size_x, then the quotient by size_y
	localparam int S2W = 2 + 3 * CW;
	localparam int S3W = 2 + 4 * CW;
	logic v_d2, v_d3;
	logic [XW-1:0] q_d2;
	logic [AW-1:0] r_d2, r_d3, dn_d3;
	logic [S2W-1:0] side_d2;
	logic [2*CW-1:0] q_d3;
	logic [S3W-1:0] side_d3;

	gcic_div #(.NW(XW), .DW(AW), .SW(S2W)) u_div_x (
		.clk(clk), .arst_n(arst_n), .en(en), .in_v(v_s4), .num(idx_s4), .den(size.sx),
		.side({op_s4, rej_s4, x_s4, y_s4, z_s4}), .out_v(v_d2), .quo(q_d2), .rem(r_d2),
		.den_out(), .side_out(side_d2)
	);
	gcic_div #(.NW(2*CW), .DW(AW), .SW(S3W)) u_div_y (
		.clk(clk), .arst_n(arst_n), .en(en), .in_v(v_d2), .num(q_d2[2*CW-1:0]),
		.den(size.sy), .side({side_d2, r_d2[CW-1:0]}), .out_v(v_d3), .quo(q_d3),
		.rem(r_d3), .den_out(dn_d3), .side_out(side_d3)
	);

	// stage 5: z * size_y + y for the forward conversion
	logic v_s5, op_s5, rej_s5;
	logic [CW-1:0] x_s5, ox_s5, oy_s5, oz_s5;
	logic [2*CW-1:0] t_s5;
	logic [CW+AW-1:0] zy;

	assign zy = side_d3[CW +: CW] * dn_d3 + (CW+AW)'(side_d3[2*CW +: CW]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_d3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s5 <= side_d3[S3W-1];
			rej_s5 <= side_d3[S3W-2];
			x_s5 <= side_d3[3*CW +: CW];
			t_s5 <= zy[2*CW-1:0];
			ox_s5 <= side_d3[CW-1:0];
			oy_s5 <= r_d3[CW-1:0];
			oz_s5 <= q_d3[CW-1:0];
		end
	end

	// stage 6: output register, t * size_x + x
	logic v_s6;
	logic [gcic_pkg::OIDX_W-1:0] idx_s6;
	logic [AW-1:0] ox_s6, oy_s6, oz_s6;
	logic ok_s6;
	logic [2*CW+AW-1:0] lin;
	logic [AW-1:0] dn_d3_hold;

	// the user must keep size_x stable while items are in flight; the block does not enforce it
	assign dn_d3_hold = size.sx;

	assign lin = t_s5 * dn_d3_hold + (2*CW+AW)'(x_s5);

	assign en = !v_s6 || dout.ready;
	assign din.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ok_s6 <= !rej_s5;
			if (op_s5 == gcic_pkg::OP_TO_INDEX) begin
				idx_s6 <= rej_s5 ? '1 : gcic_pkg::OIDX_W'(lin[XW-1:0]);
				ox_s6 <= '0;
				oy_s6 <= '0;
				oz_s6 <= '0;
			end else begin
				idx_s6 <= '0;
				ox_s6 <= rej_s5 ? '1 : AW'(ox_s5);
				oy_s6 <= rej_s5 ? '1 : AW'(oy_s5);
				oz_s6 <= rej_s5 ? '1 : AW'(oz_s5);
			end
		end
	end

	assign dout.valid = v_s6;
	assign dout.out_index = idx_s6;
	assign dout.out_x = ox_s6;
	assign dout.out_y = oy_s6;
	assign dout.out_z = oz_s6;
	assign dout.valid_res = ok_s6;

	a_ok_fields: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid && dout.valid_res |-> dout.out_index == '0
			|| (dout.out_x == '0 && dout.out_y == '0 && dout.out_z == '0))
		else $error("successful result has fields of both ops");

	a_rej_fields: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid && !dout.valid_res |->
			(dout.out_index == '1 && dout.out_x == '0 && dout.out_y == '0 && dout.out_z == '0)
			|| (dout.out_index == '0 && dout.out_x == '1 && dout.out_y == '1
				&& dout.out_z == '1))
		else $error("rejected result without sentinel");

	a_coord_range: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid && dout.valid_res |-> $unsigned(dout.out_x) < size.sx
			&& $unsigned(dout.out_y) < size.sy && $unsigned(dout.out_z) < size.sz)
		else $error("coordinate beyond axis size");

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
class conv_scoreboard;
	typedef struct {
		logic signed [30:0] idx;
		logic signed [10:0] x;
		logic signed [10:0] y;
		logic signed [10:0] z;
		logic ok;
	} conv_result_t;

	conv_result_t pending[$];
	int errors;
	longint sx, sy, sz;

	function new();
		errors = 0;
		set_sizes(11'd1, 11'd1, 11'd1);
	endfunction

	function longint eff(logic [10:0] r);
		if (r == 0) return 1;
		if (r > 1024) return 1024;
		return r;
	endfunction

	function void set_sizes(logic [10:0] a, logic [10:0] b, logic [10:0] c);
		sx = eff(a);
		sy = eff(b);
		sz = eff(c);
	endfunction

	function longint fmod(longint v, longint m);
		longint r;
		r = v % m;
		if (r < 0) r += m;
		return r;
	endfunction

	function void note_request(logic op, logic wrap, logic signed [31:0] cx,
		logic signed [31:0] cy, logic signed [31:0] cz, logic signed [31:0] li);
		conv_result_t e;
		longint x, y, z, idx, plane, total;
		e = '{default: '0};
		x = cx; y = cy; z = cz; idx = li;
		plane = sx * sy;
		total = plane * sz;
		if (op == gcic_pkg::OP_TO_INDEX) begin
			if (wrap) begin
				x = fmod(x, sx); y = fmod(y, sy); z = fmod(z, sz);
			end
			if (x < 0 || y < 0 || z < 0 || x >= sx || y >= sy || z >= sz) begin
				e.idx = '1;
			end else begin
				e.idx = 31'(x + y * sx + z * plane);
				e.ok = 1'b1;
			end
		end else begin
			if (wrap) idx = fmod(idx, total);
			if (idx < 0 || idx >= total) begin
				e.x = '1; e.y = '1; e.z = '1;
			end else begin
				e.z = 11'(idx / plane);
				e.y = 11'((idx / sx) % sy);
				e.x = 11'(idx % sx);
				e.ok = 1'b1;
			end
		end
		pending.push_back(e);
	endfunction

	function void check_result(logic signed [30:0] idx, logic signed [10:0] x,
		logic signed [10:0] y, logic signed [10:0] z, logic ok);
		conv_result_t e;
		if (pending.size() == 0) begin
			$display("%0t: unexpected result idx=%0d x=%0d y=%0d z=%0d ok=%0b",
				$time, idx, x, y, z, ok);
			errors++;
			return;
		end
		e = pending.pop_front();
		if (e.idx !== idx || e.x !== x || e.y !== y || e.z !== z || e.ok !== ok) begin
			$display("%0t: expected idx=%0d x=%0d y=%0d z=%0d ok=%0b, got idx=%0d x=%0d y=%0d z=%0d ok=%0b",
				$time, e.idx, e.x, e.y, e.z, e.ok, idx, x, y, z, ok);
			errors++;
		end
	endfunction
endclass

module tb;
	localparam int LATENCY = 88;
	localparam int WATCHDOG = 20000;

	logic clk = 0;
	logic arst_n = 0;
	logic wr_en = 0;
	logic [gcic_pkg::REG_IDX_W-1:0] wr_idx = gcic_pkg::REG_SIZE_X;
	logic [gcic_pkg::AXIS_W-1:0] wr_data = 0;
	int src_idle_pct = 0;
	int snk_idle_pct = 0;
	bit hold_off = 0;
	int quiet_cycles = 0;
	conv_scoreboard board;

	gcic_in_if din();
	gcic_out_if dout();

	grid_coord_index_convert dut (
		.clk(clk), .arst_n(arst_n), .din(din.sink), .dout(dout.source),
		.wr_en(wr_en), .wr_idx(wr_idx), .wr_data(wr_data)
	);

	always #5 clk = ~clk;

	initial begin
		din.valid = 0; din.op = 0; din.wrap = 0;
		din.coord_x = 0; din.coord_y = 0; din.coord_z = 0; din.lin_index = 0;
		dout.ready = 0;
	end

	// scoreboard and sink side: random stall, plus a long hold-off on request
	always @(posedge clk) begin
		if (dout.valid && dout.ready)
			board.check_result(dout.out_index, dout.out_x, dout.out_y, dout.out_z,
				dout.valid_res);
		if (din.valid && din.ready)
			board.note_request(din.op, din.wrap, din.coord_x, din.coord_y,
				din.coord_z, din.lin_index);
		quiet_cycles <= (din.valid && din.ready) || (dout.valid && dout.ready) ?
			0 : quiet_cycles + 1;
		dout.ready <= !hold_off && ($urandom_range(99) >= snk_idle_pct);
	end

	always @(posedge clk) begin
		if (quiet_cycles > WATCHDOG) begin
			$display("grid_coord_index_convert: mismatch");
			$finish;
		end
	end

	task automatic write_size(gcic_pkg::reg_idx_t r, logic [gcic_pkg::AXIS_W-1:0] v);
		wr_en <= 1'b1; wr_idx <= r; wr_data <= v;
		@(posedge clk);
	endtask

	task automatic set_grid(logic [10:0] a, logic [10:0] b, logic [10:0] c);
		write_size(gcic_pkg::REG_SIZE_X, a);
		write_size(gcic_pkg::REG_SIZE_Y, b);
		write_size(gcic_pkg::REG_SIZE_Z, c);
		wr_en <= 1'b0;
		board.set_sizes(a, b, c);
	endtask

	task automatic send(logic op, logic wrap, logic signed [31:0] cx,
		logic signed [31:0] cy, logic signed [31:0] cz, logic signed [31:0] li);
		while ($urandom_range(99) < src_idle_pct) begin
			din.valid <= 0;
			@(posedge clk);
		end
		din.valid <= 1; din.op <= op; din.wrap <= wrap;
		din.coord_x <= cx; din.coord_y <= cy; din.coord_z <= cz; din.lin_index <= li;
		@(posedge clk);
		while (!din.ready) @(posedge clk);
	endtask

	task automatic drain();
		din.valid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	function automatic logic signed [31:0] rand_val(longint s);
		unique case ($urandom_range(5))
			0: return $urandom;
			1: return -$signed({1'b0, 31'($urandom_range(3000))});
			2: return $urandom_range(32'(s - 1));
			3: return 32'(s);
			4: return 32'(s + $urandom_range(5));
			default: return $urandom_range(32'(s * 3));
		endcase
	endfunction

	task automatic random_items(int n);
		longint t;
		logic o, w;
		for (int i = 0; i < n; i++) begin
			t = board.sx * board.sy * board.sz;
			o = 1'($urandom); w = 1'($urandom);
			send(o, w, rand_val(board.sx), rand_val(board.sy), rand_val(board.sz),
				rand_val(t));
		end
	endtask

	initial begin
		board = new();
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: reset sizes, then extremes
		send(gcic_pkg::OP_TO_INDEX, 1'b0, 0, 0, 0, 0);
		send(gcic_pkg::OP_TO_COORD, 1'b0, 0, 0, 0, 0);
		send(gcic_pkg::OP_TO_COORD, 1'b1, 0, 0, 0, 32'sh7fffffff);
		drain();
		set_grid(11'd1024, 11'd1024, 11'd1024);
		send(gcic_pkg::OP_TO_INDEX, 1'b0, 1023, 1023, 1023, 0);
		send(gcic_pkg::OP_TO_INDEX, 1'b0, 1024, 0, 0, 0);
		send(gcic_pkg::OP_TO_INDEX, 1'b0, -1, 0, 0, 0);
		send(gcic_pkg::OP_TO_INDEX, 1'b1, 32'sh80000000, 32'sh7fffffff, -1, 0);
		send(gcic_pkg::OP_TO_COORD, 1'b0, 0, 0, 0, 32'sh3fffffff);
		send(gcic_pkg::OP_TO_COORD, 1'b0, 0, 0, 0, 32'sh40000000);
		send(gcic_pkg::OP_TO_COORD, 1'b1, 0, 0, 0, 32'sh80000000);
		send(gcic_pkg::OP_TO_COORD, 1'b1, 0, 0, 0, -1);
		send(gcic_pkg::OP_TO_COORD, 1'b0, 0, 0, 0, -1);
		drain();
		// size zero acts as one, above max acts as max
		set_grid(11'd0, 11'd2047, 11'd3);
		send(gcic_pkg::OP_TO_INDEX, 1'b0, 0, 1023, 2, 0);
		send(gcic_pkg::OP_TO_COORD, 1'b0, 0, 0, 0, 3071);
		send(gcic_pkg::OP_TO_COORD, 1'b1, 0, 0, 0, 3072);
		send(gcic_pkg::OP_TO_INDEX, 1'b1, 5, 2048, -7, 0);
		drain();
		for (int ph = 0; ph < 6; ph++) begin
			unique case (ph % 3)
				0: begin src_idle_pct = 37; snk_idle_pct = 48; end
				1: begin src_idle_pct = 48; snk_idle_pct = 37; end
				default: begin src_idle_pct = 0; snk_idle_pct = 0; end
			endcase
			set_grid(11'($urandom_range(1, 17)), 11'($urandom_range(1, 1024)),
				11'($urandom_range(0, 2047)));
			if (ph == 2) begin
				fork
					random_items(260);
					begin
						hold_off = 1;
						repeat (300) @(posedge clk);
						hold_off = 0;
					end
				join
			end else
				random_items(260);
			drain();
		end
		if (board.errors == 0 && board.pending.size() == 0)
			$display("grid_coord_index_convert: match");
		else
			$display("grid_coord_index_convert: mismatch");
		$finish;
	end
endmodule

FILE: sim.f
hdl/gcic_pkg.sv
hdl/gcic_if.sv
hdl/gcic_cfg.sv
hdl/gcic_div.sv
hdl/grid_coord_index_convert.sv
test/tb.sv
